// ----- hw/rtl/lzwc_pkg.sv -----
package lzwc_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_CMP,
        ST_EMIT_MISS,
        ST_EMIT_LAST
    } t_state;

    localparam int unsigned FIRST_FREE = 256;

endpackage

// ----- hw/rtl/lzwc_ram.sv -----
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/lzw_compressor_12bit_core.sv -----
// LZW compressor, one byte per item, codes up to DICT_CODES-1 (low 12 bits shown).
// Steps: an item is taken in ST_IDLE and, when the prefix is empty, just becomes the prefix;
// else the dictionary RAM is probed (registered read, compare), with a wait state before each
// further probe, and each code is emitted into the output register; an emit waits on i_stall.
// A new item is taken only when the block is back in ST_IDLE.
// Reset (synchronous) and each end of stream clear all TABLE_ENTRIES slots, one per cycle.
module lzw_compressor_12bit_core #(
    parameter int DICT_CODES    = 4096,
    parameter int TABLE_ENTRIES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_out_code,
    output logic        o_last_code
);

    localparam int CW = $clog2(DICT_CODES);    // code width
    localparam int NW = CW + 1;                // next free code width
    localparam int AW = $clog2(TABLE_ENTRIES); // slot address width
    localparam int KW = CW + 8;                // key width
    localparam int EW = 1 + KW + CW;           // entry: valid, key, code

    // Control state.
    lzwc_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW:0]   r_cnt, n_cnt;      // slots probed so far
    logic          r_pvalid, n_pvalid;
    logic [NW-1:0] r_next, n_next;
    logic          r_ovalid, n_ovalid;
    // Payload.
    logic [CW-1:0] r_prefix, n_prefix;
    logic [7:0]    r_byte, n_byte;
    logic          r_final, n_final;
    logic [11:0]   r_ocode, n_ocode;
    logic          r_olast, n_olast;

    logic          we;
    logic [EW-1:0] wdata, rdata;
    logic [KW-1:0] key;
    logic [KW-1:0] in_key;
    logic          hit_valid, hit_match;
    logic [AW-1:0] home;

    assign key    = {r_prefix, r_byte};
    assign in_key = {r_prefix, i_data_byte};
    assign home   = in_key[AW-1:0];  // key modulo table size; table size is a power of two
    assign hit_valid = rdata[EW-1];
    assign hit_match = rdata[EW-2 -: KW] == key;

    lzwc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_dict (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_addr),
        .i_wdata(wdata),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    // The output register parts the two sides: a new item may be taken while a code waits.
    assign o_stall     = (r_state != lzwc_pkg::ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_out_code  = r_ocode;
    assign o_last_code = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzwc_pkg::ST_CLEAR;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_pvalid <= 1'b0;
            r_next   <= NW'(lzwc_pkg::FIRST_FREE);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_pvalid <= n_pvalid;
            r_next   <= n_next;
            r_ovalid <= n_ovalid;
        end
        r_prefix <= n_prefix;
        r_byte   <= n_byte;
        r_final  <= n_final;
        r_ocode  <= n_ocode;
        r_olast  <= n_olast;
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_pvalid = r_pvalid;
        n_next   = r_next;
        n_ovalid = r_ovalid && i_stall;
        n_prefix = r_prefix;
        n_byte   = r_byte;
        n_final  = r_final;
        n_ocode  = r_ocode;
        n_olast  = r_olast;
        we       = 1'b0;
        wdata    = '0;
        unique case (r_state)
            lzwc_pkg::ST_CLEAR: begin
                // Sweep every slot invalid, then start a fresh stream.
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == AW'(TABLE_ENTRIES - 1)) begin
                    n_state  = lzwc_pkg::ST_IDLE;
                    n_pvalid = 1'b0;
                    n_next   = NW'(lzwc_pkg::FIRST_FREE);
                    n_prefix = '0;
                end
            end
            lzwc_pkg::ST_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_byte  = i_data_byte;
                    n_final = i_final_byte;
                    if (!r_pvalid) begin
                        n_prefix = CW'(i_data_byte);
                        n_pvalid = 1'b1;
                        if (i_final_byte) begin
                            n_state = lzwc_pkg::ST_EMIT_LAST;
                        end
                    end else begin
                        n_addr  = home;
                        n_cnt   = '0;
                        n_state = lzwc_pkg::ST_RD;
                    end
                end
            end
            lzwc_pkg::ST_RD: begin
                // Address is on the RAM; data arrives next cycle.
                n_state = lzwc_pkg::ST_CMP;
            end
            lzwc_pkg::ST_WAIT: begin
                n_state = lzwc_pkg::ST_RD;
            end
            lzwc_pkg::ST_CMP: begin
                if (!hit_valid) begin
                    // Empty slot: miss, insert while codes remain.
                    if (r_next < NW'(DICT_CODES)) begin
                        we     = 1'b1;
                        wdata  = {1'b1, key, r_next[CW-1:0]};
                        n_next = r_next + 1'b1;
                    end
                    n_state = lzwc_pkg::ST_EMIT_MISS;
                end else if (hit_match) begin
                    n_prefix = rdata[CW-1:0];
                    n_state  = r_final ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
                end else if (r_cnt == (AW+1)'(TABLE_ENTRIES - 1)) begin
                    // Table full of other keys: miss without insert.
                    n_state = lzwc_pkg::ST_EMIT_MISS;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = lzwc_pkg::ST_WAIT;
                end
            end
            lzwc_pkg::ST_EMIT_MISS: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ocode  = 12'(r_prefix);
                    n_olast  = 1'b0;
                    n_prefix = CW'(r_byte);
                    n_state  = r_final ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
                end
            end
            lzwc_pkg::ST_EMIT_LAST: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ocode  = 12'(r_prefix);
                    n_olast  = 1'b1;
                    n_addr   = '0;
                    n_state  = lzwc_pkg::ST_CLEAR;
                end
            end
            default: n_state = lzwc_pkg::ST_CLEAR;
        endcase
    end

    // No item is taken while the block works on one.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lzwc_pkg::ST_IDLE) |-> o_stall)
        else $error("item accepted while busy");

    // The free code counter never passes the dictionary size.
    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= NW'(DICT_CODES))
        else $error("next free code overflow");

    // A final code is always followed by the clearing pass.
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwc_pkg::ST_EMIT_LAST && (!r_ovalid || !i_stall))
        |=> (r_state == lzwc_pkg::ST_CLEAR))
        else $error("no clear after final code");

endmodule

// ----- dv/tb_lzw_compressor_12bit_core.sv -----
`timescale 1ns / 1ps

module tb_lzw_compressor_12bit_core;

    // The dictionary sizes match the block's defaults.
    localparam int DICT_CODES    = 4096;
    localparam int TABLE_ENTRIES = 8192;
    localparam int FREE_CODE     = 256;
    // A directed row either carries a typed-in expectation or defers to the predictor.
    localparam bit ROW_PREDICT   = 1'b0;
    localparam bit ROW_TYPED     = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_out_code;
    logic        o_last_code;

    lzw_compressor_12bit_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_code   (o_out_code),
        .o_last_code  (o_last_code)
    );

    typedef struct packed {
        logic [11:0] code;
        logic        last;
    } t_code_item;

    // Predictor state: the current prefix, the next code to hand out and the hash table.
    logic [11:0] pfx_code;
    logic        pfx_valid;
    int unsigned next_code;
    logic        slot_used [TABLE_ENTRIES];
    logic [19:0] slot_key  [TABLE_ENTRIES];
    logic [11:0] slot_code [TABLE_ENTRIES];

    t_code_item  pending_codes[$];
    int          fail_count;
    bit          stim_done;
    bit          long_hold_req;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic void clear_dictionary();
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            slot_used[s] = 1'b0;
            slot_key[s]  = '0;
            slot_code[s] = '0;
        end
        pfx_code  = '0;
        pfx_valid = 1'b0;
        next_code = FREE_CODE;
    endfunction

    // Runs one byte through the compressor model and queues the codes it emits.
    function automatic void compress_byte(input logic [7:0] b, input logic fin);
        logic [19:0] key;
        int unsigned pos;
        int          found;
        t_code_item  c;
        if (!pfx_valid) begin
            pfx_code  = {4'd0, b};
            pfx_valid = 1'b1;
        end else begin
            key   = {pfx_code, b};
            pos   = key % TABLE_ENTRIES;
            found = -1;
            for (int n = 0; n < TABLE_ENTRIES; n++) begin
                if (!slot_used[pos]) begin
                    found = 0;
                    break;
                end
                if (slot_key[pos] == key) begin
                    found = 1;
                    break;
                end
                pos = (pos + 1) % TABLE_ENTRIES;
            end
            if (found == 1) begin
                pfx_code = slot_code[pos];
            end else begin
                c.code = pfx_code;
                c.last = 1'b0;
                pending_codes.push_back(c);
                if (found == 0 && next_code < DICT_CODES) begin
                    slot_used[pos] = 1'b1;
                    slot_key[pos]  = key;
                    slot_code[pos] = next_code[11:0];
                    next_code++;
                end
                pfx_code = {4'd0, b};
            end
        end
        if (fin) begin
            c.code = pfx_code;
            c.last = 1'b1;
            pending_codes.push_back(c);
            clear_dictionary();
        end
    endfunction

    // Called at a falling edge; the item is dropped again at the falling edge after it is taken.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        i_valid      = 1'b1;
        i_data_byte  = b;
        i_final_byte = fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        compress_byte(b, fin);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic idle_gap();
        int unsigned g;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        repeat (g) @(negedge i_clk);
    endtask

    // Directed rows: single-byte streams, with their codes typed in, then patterns
    // that build and reuse dictionary strings, left to the predictor.
    typedef struct {
        logic [7:0]  b;
        logic        fin;
        bit          typed;
        logic [11:0] code;
    } t_row;

    t_row rows [18] = '{
        '{8'h00, 1'b1, ROW_TYPED,   12'h000},
        '{8'hFF, 1'b1, ROW_TYPED,   12'h0FF},
        '{8'hA5, 1'b1, ROW_TYPED,   12'h0A5},
        '{8'h41, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h41, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h41, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h41, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h42, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h41, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h42, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h41, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h42, 1'b1, ROW_PREDICT, 12'h000},
        '{8'h00, 1'b0, ROW_PREDICT, 12'h000},
        '{8'hFF, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h00, 1'b0, ROW_PREDICT, 12'h000},
        '{8'hFF, 1'b0, ROW_PREDICT, 12'h000},
        '{8'h00, 1'b0, ROW_PREDICT, 12'h000},
        '{8'hFF, 1'b1, ROW_PREDICT, 12'h000}
    };

    // Stimulus. Random streams mostly use a small alphabet so that strings repeat
    // and matches chain deep.
    initial begin
        t_code_item  c;
        int unsigned len;
        int unsigned alpha;
        int unsigned sent;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data_byte  = '0;
        i_final_byte = 1'b0;
        fail_count   = 0;
        stim_done    = 1'b0;
        long_hold_req = 1'b0;
        clear_dictionary();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].typed) begin
                c.code = rows[r].code;
                c.last = 1'b1;
                pending_codes.push_back(c);
                clear_dictionary();
                send_byte(rows[r].b, rows[r].fin);
                // The typed-in code replaces what the predictor would have queued.
                void'(pending_codes.pop_back());
            end else begin
                send_byte(rows[r].b, rows[r].fin);
            end
            idle_gap();
        end

        // The sender pauses until every expected code has come back.
        while (pending_codes.size() != 0) @(negedge i_clk);

        sent = 0;
        while (sent < 1200) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 60);
            alpha = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(2, 8);
            if (sent >= 300 && sent < 360) long_hold_req = 1'b1;
            for (int k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(0, alpha - 1) + ((alpha == 256) ? 0 : 8'h61)),
                          (k == len - 1));
                sent++;
                if (!long_hold_req) idle_gap();
            end
            long_hold_req = 1'b0;
        end

        while (pending_codes.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        stim_done = 1'b1;
    end

    // The receiver stalls at random; once it holds off for a long stretch while the
    // sender keeps offering bytes back to back.
    initial begin
        int unsigned g;
        bit          long_done;
        i_stall   = 1'b1;
        long_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_done) begin
                long_done = 1'b1;
                i_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
            end
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            i_stall <= (g != 0);
            if (g != 0) begin
                repeat (g - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Checker: every accepted code is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_code_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected code %0d last %0b",
                                          o_out_code, o_last_code));
            end else begin
                e = pending_codes.pop_front();
                if (o_out_code !== e.code)
                    report_mismatch($sformatf("out_code %0d, expected %0d",
                                              o_out_code, e.code));
                if (o_last_code !== e.last)
                    report_mismatch($sformatf("last_code %0b, expected %0b",
                                              o_last_code, e.last));
            end
        end
    end

    initial begin
        wait (stim_done);
        if (pending_codes.size() != 0)
            report_mismatch($sformatf("%0d codes never arrived", pending_codes.size()));
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Each clearing pass sweeps all TABLE_ENTRIES slots; the directed rows and the random
    // streams, even with the longest stalls, stay well below this bound.
    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- lzw_compressor_12bit_core.f -----
hw/rtl/lzwc_pkg.sv
hw/rtl/lzwc_ram.sv
hw/rtl/lzw_compressor_12bit_core.sv
dv/tb_lzw_compressor_12bit_core.sv
